// File: rtl/ghal_pkg.sv
// ----------------------------------------------------------------------------
// ghal_pkg: shared types and constants of the generational handle allocator
// Holds the request and status codes, the controller states and the command
// and status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ghal_pkg;

  // Field widths of the request and result words.
  localparam int MODE_W      = 2;
  localparam int IDX_IN_W    = 8;
  localparam int GEN_IN_W    = 16;
  localparam int STATUS_W    = 3;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  // Request modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC    = 2'd0,
    MODE_ALLOC_AT = 2'd1,
    MODE_RELEASE  = 2'd2,
    MODE_QUERY    = 2'd3
  } mode_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_ACTIVE    = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_ALIVE = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_BUMP,
    S_GROW,
    S_AT_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SET,
    S_HANDLE_CHK,
    S_RESULT
  } state_t;

  // Kinds of write into the slot table.
  typedef enum logic [2:0] {
    SW_NONE,
    SW_BUMP,
    SW_FRESH,
    SW_GROW,
    SW_SET,
    SW_RELEASE
  } slot_wr_t;

  // Kinds of push onto the free stack.
  typedef enum logic [1:0] {
    PUSH_NONE,
    PUSH_USED,
    PUSH_IDX
  } push_t;

  // Where the index and generation of a result come from.
  typedef enum logic [1:0] {
    RES_FRESH,
    RES_POP,
    RES_ECHO,
    RES_ZERO
  } res_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      capture;
    logic      stk_rd_top;
    logic      stk_rd_scan;
    logic      slot_rd_idx;
    logic      slot_rd_pop;
    slot_wr_t  slot_wr;
    push_t     push;
    logic      scan_step;
    logic      drop_found;
    logic      used_inc;
    logic      used_set;
    logic      res_load;
    res_kind_t res_kind;
    logic      res_alive;
    status_t   res_status;
    logic      out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    mode_t mode;
    logic  idx_oor;
    logic  idx_below_used;
    logic  used_lt_idx;
    logic  free_empty;
    logic  used_full;
    logic  slot_active;
    logic  gen_match;
    logic  scan_last;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/ghal_ctrl.sv
// ----------------------------------------------------------------------------
// ghal_ctrl: sequencer of the generational handle allocator
// Steps each request through its table and stack accesses and tells the
// datapath what to read, write and report in every cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ghal_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output      logic            in_tready,
  input  wire ghal_pkg::sts_t  sts,
  output      ghal_pkg::cmd_t  cmd
);

  ghal_pkg::state_t state_r;
  ghal_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ghal_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ghal_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ghal_pkg::S_DECODE;
        end
      end
      ghal_pkg::S_DECODE: begin
        case (sts.mode)
          ghal_pkg::MODE_ALLOC: begin
            state_nxt = sts.free_empty ? ghal_pkg::S_RESULT : ghal_pkg::S_POP;
          end
          ghal_pkg::MODE_ALLOC_AT: begin
            if (sts.idx_oor) begin
              state_nxt = ghal_pkg::S_RESULT;
            end else if (sts.idx_below_used) begin
              state_nxt = ghal_pkg::S_AT_CHK;
            end else begin
              state_nxt = ghal_pkg::S_GROW;
            end
          end
          default: begin
            if (!sts.idx_oor && sts.idx_below_used) begin
              state_nxt = ghal_pkg::S_HANDLE_CHK;
            end else begin
              state_nxt = ghal_pkg::S_RESULT;
            end
          end
        endcase
      end
      ghal_pkg::S_POP:        state_nxt = ghal_pkg::S_BUMP;
      ghal_pkg::S_BUMP:       state_nxt = ghal_pkg::S_RESULT;
      ghal_pkg::S_GROW: begin
        if (!sts.used_lt_idx) begin
          state_nxt = ghal_pkg::S_SET;
        end
      end
      ghal_pkg::S_AT_CHK: begin
        if (sts.slot_active) begin
          state_nxt = ghal_pkg::S_RESULT;
        end else if (sts.free_empty) begin
          state_nxt = ghal_pkg::S_SET;
        end else begin
          state_nxt = ghal_pkg::S_SCAN_RD;
        end
      end
      ghal_pkg::S_SCAN_RD:    state_nxt = ghal_pkg::S_SCAN_CHK;
      ghal_pkg::S_SCAN_CHK: begin
        state_nxt = sts.scan_last ? ghal_pkg::S_SET : ghal_pkg::S_SCAN_RD;
      end
      ghal_pkg::S_SET:        state_nxt = ghal_pkg::S_RESULT;
      ghal_pkg::S_HANDLE_CHK: state_nxt = ghal_pkg::S_RESULT;
      ghal_pkg::S_RESULT: begin
        if (sts.out_free) begin
          state_nxt = ghal_pkg::S_IDLE;
        end
      end
      default:                state_nxt = ghal_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ghal_pkg::S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ghal_pkg::S_DECODE: begin
        case (sts.mode)
          ghal_pkg::MODE_ALLOC: begin
            if (!sts.free_empty) begin
              cmd.stk_rd_top = 1'b1;
            end else if (!sts.used_full) begin
              // Take the next fresh slot at generation one.
              cmd.slot_wr    = ghal_pkg::SW_FRESH;
              cmd.used_inc   = 1'b1;
              cmd.res_load   = 1'b1;
              cmd.res_kind   = ghal_pkg::RES_FRESH;
              cmd.res_alive  = 1'b1;
              cmd.res_status = ghal_pkg::ST_OK;
            end else begin
              cmd.res_load   = 1'b1;
              cmd.res_kind   = ghal_pkg::RES_ZERO;
              cmd.res_status = ghal_pkg::ST_FULL;
            end
          end
          ghal_pkg::MODE_ALLOC_AT: begin
            if (sts.idx_oor) begin
              cmd.res_load   = 1'b1;
              cmd.res_kind   = ghal_pkg::RES_ECHO;
              cmd.res_status = ghal_pkg::ST_RANGE;
            end else if (sts.idx_below_used) begin
              cmd.slot_rd_idx = 1'b1;
            end
          end
          default: begin
            if (sts.idx_oor) begin
              cmd.res_load   = 1'b1;
              cmd.res_kind   = ghal_pkg::RES_ECHO;
              cmd.res_status = ghal_pkg::ST_RANGE;
            end else if (sts.idx_below_used) begin
              cmd.slot_rd_idx = 1'b1;
            end else begin
              cmd.res_load   = 1'b1;
              cmd.res_kind   = ghal_pkg::RES_ECHO;
              cmd.res_status = ghal_pkg::ST_NOT_ALIVE;
            end
          end
        endcase
      end
      ghal_pkg::S_POP: begin
        cmd.slot_rd_pop = 1'b1;
      end
      ghal_pkg::S_BUMP: begin
        cmd.slot_wr    = ghal_pkg::SW_BUMP;
        cmd.res_load   = 1'b1;
        cmd.res_kind   = ghal_pkg::RES_POP;
        cmd.res_alive  = 1'b1;
        cmd.res_status = ghal_pkg::ST_OK;
      end
      ghal_pkg::S_GROW: begin
        // One skipped slot is cleared and pushed per cycle.
        if (sts.used_lt_idx) begin
          cmd.slot_wr  = ghal_pkg::SW_GROW;
          cmd.push     = ghal_pkg::PUSH_USED;
          cmd.used_inc = 1'b1;
        end
      end
      ghal_pkg::S_AT_CHK: begin
        if (sts.slot_active) begin
          cmd.res_load   = 1'b1;
          cmd.res_kind   = ghal_pkg::RES_ECHO;
          cmd.res_status = ghal_pkg::ST_ACTIVE;
        end
      end
      ghal_pkg::S_SCAN_RD: begin
        cmd.stk_rd_scan = 1'b1;
      end
      ghal_pkg::S_SCAN_CHK: begin
        cmd.scan_step = 1'b1;
      end
      ghal_pkg::S_SET: begin
        cmd.slot_wr    = ghal_pkg::SW_SET;
        cmd.used_set   = 1'b1;
        cmd.drop_found = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_kind   = ghal_pkg::RES_ECHO;
        cmd.res_alive  = 1'b1;
        cmd.res_status = ghal_pkg::ST_OK;
      end
      ghal_pkg::S_HANDLE_CHK: begin
        cmd.res_load = 1'b1;
        cmd.res_kind = ghal_pkg::RES_ECHO;
        if (sts.slot_active && sts.gen_match) begin
          cmd.res_status = ghal_pkg::ST_OK;
          if (sts.mode == ghal_pkg::MODE_RELEASE) begin
            cmd.slot_wr = ghal_pkg::SW_RELEASE;
            cmd.push    = ghal_pkg::PUSH_IDX;
          end else begin
            cmd.res_alive = 1'b1;
          end
        end else begin
          cmd.res_status = ghal_pkg::ST_NOT_ALIVE;
        end
      end
      ghal_pkg::S_RESULT: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/ghal_dp.sv
// ----------------------------------------------------------------------------
// ghal_dp: datapath of the generational handle allocator
// Holds the slot table, the free stack, the counters, the request and
// result registers and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ghal_dp #(
  parameter int CAPACITY = 256,
  parameter int GEN_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire ghal_pkg::cmd_t                      cmd,
  output      ghal_pkg::sts_t                      sts,
  input  wire logic [ghal_pkg::IN_TDATA_W-1:0]     in_tdata,
  output      logic                                out_tvalid,
  input  wire logic                                out_tready,
  output      logic [ghal_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int SLOT_W = GEN_BITS + 1;

  // Slot table: active bit over generation. Only slots below the used
  // count are ever read, and all of those have been written.
  logic [SLOT_W-1:0] slot_mem [CAPACITY];
  logic [SLOT_W-1:0] slot_rdata_r;
  logic              slot_we;
  logic [IDX_W-1:0]  slot_waddr;
  logic [SLOT_W-1:0] slot_wdata;
  logic              slot_re;
  logic [IDX_W-1:0]  slot_raddr;

  // Free stack of slot indices.
  logic [IDX_W-1:0] stk_mem [CAPACITY];
  logic [IDX_W-1:0] stk_rdata_r;
  logic             stk_we;
  logic [IDX_W-1:0] stk_waddr;
  logic [IDX_W-1:0] stk_wdata;
  logic             stk_re;
  logic [IDX_W-1:0] stk_raddr;

  // Counters and walk state.
  logic [CNT_W-1:0] free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] scan_ptr_r, scan_ptr_nxt;
  logic             found_r, found_nxt;
  logic             push_ok;

  // Request registers.
  ghal_pkg::mode_t                mode_r;
  logic [ghal_pkg::IDX_IN_W-1:0]  idx_r;
  logic [ghal_pkg::GEN_IN_W-1:0]  gen_in_r;
  logic [IDX_W-1:0]               slot_r;
  logic [IDX_W-1:0]               idx_slot;
  logic [GEN_BITS-1:0]            gen_req;
  logic [GEN_BITS-1:0]            gen_bumped;

  // Result and output registers.
  logic [ghal_pkg::IDX_IN_W-1:0]  res_index_r;
  logic [ghal_pkg::GEN_IN_W-1:0]  res_gen_r;
  logic                           res_alive_r;
  ghal_pkg::status_t              res_status_r;
  logic                           out_valid_r, out_valid_nxt;
  logic [ghal_pkg::OUT_TDATA_W-1:0] out_data_r;

  assign idx_slot   = IDX_W'(idx_r);
  assign gen_req    = GEN_BITS'(gen_in_r);
  assign gen_bumped = slot_rdata_r[GEN_BITS-1:0] + 1'b1;
  assign push_ok    = (cmd.push != ghal_pkg::PUSH_NONE) &&
                      (free_cnt_r != CNT_W'(CAPACITY));

  // Status toward the controller.
  always_comb begin
    sts.mode           = mode_r;
    sts.idx_oor        = 32'(idx_r) >= 32'(CAPACITY);
    sts.idx_below_used = 32'(idx_r) < 32'(used_r);
    sts.used_lt_idx    = 32'(used_r) < 32'(idx_r);
    sts.free_empty     = free_cnt_r == '0;
    sts.used_full      = used_r == CNT_W'(CAPACITY);
    sts.slot_active    = slot_rdata_r[GEN_BITS];
    sts.gen_match      = slot_rdata_r[GEN_BITS-1:0] == gen_req;
    sts.scan_last      = (scan_ptr_r + 1'b1) == free_cnt_r;
    sts.out_free       = !out_valid_r || out_tready;
  end

  // Slot table write and read selection.
  always_comb begin
    slot_we    = 1'b1;
    slot_waddr = idx_slot;
    slot_wdata = {1'b1, gen_req};
    case (cmd.slot_wr)
      ghal_pkg::SW_BUMP: begin
        slot_waddr = slot_r;
        slot_wdata = {1'b1, gen_bumped};
      end
      ghal_pkg::SW_FRESH: begin
        slot_waddr = IDX_W'(used_r);
        slot_wdata = {1'b1, GEN_BITS'(1)};
      end
      ghal_pkg::SW_GROW: begin
        slot_waddr = IDX_W'(used_r);
        slot_wdata = '0;
      end
      ghal_pkg::SW_SET: begin
        slot_wdata = {1'b1, gen_req};
      end
      ghal_pkg::SW_RELEASE: begin
        slot_wdata = {1'b0, slot_rdata_r[GEN_BITS-1:0]};
      end
      default: begin
        slot_we = 1'b0;
      end
    endcase
    slot_re    = cmd.slot_rd_idx || cmd.slot_rd_pop;
    slot_raddr = cmd.slot_rd_pop ? stk_rdata_r : idx_slot;
  end

  // Free stack write and read selection.
  always_comb begin
    stk_we    = push_ok || (cmd.scan_step && found_r);
    stk_waddr = IDX_W'(free_cnt_r);
    stk_wdata = stk_rdata_r;
    if (push_ok) begin
      stk_wdata = (cmd.push == ghal_pkg::PUSH_USED) ? IDX_W'(used_r) : idx_slot;
    end else begin
      // Entries above the removed one move down by one place.
      stk_waddr = IDX_W'(scan_ptr_r - 1'b1);
    end
    stk_re    = cmd.stk_rd_top || cmd.stk_rd_scan;
    stk_raddr = cmd.stk_rd_top ? IDX_W'(free_cnt_r - 1'b1) : IDX_W'(scan_ptr_r);
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rdata_r <= slot_mem[slot_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_r <= stk_mem[stk_raddr];
    end
  end

  // Counter and walk updates.
  always_comb begin
    free_cnt_nxt = free_cnt_r;
    if (cmd.stk_rd_top || (cmd.drop_found && found_r)) begin
      free_cnt_nxt = free_cnt_r - 1'b1;
    end else if (push_ok) begin
      free_cnt_nxt = free_cnt_r + 1'b1;
    end

    used_nxt = used_r;
    if (cmd.used_inc) begin
      used_nxt = used_r + 1'b1;
    end else if (cmd.used_set && !sts.idx_below_used) begin
      used_nxt = CNT_W'(idx_r) + 1'b1;
    end

    scan_ptr_nxt = scan_ptr_r;
    found_nxt    = found_r;
    if (cmd.capture) begin
      scan_ptr_nxt = '0;
      found_nxt    = 1'b0;
    end else if (cmd.scan_step) begin
      scan_ptr_nxt = scan_ptr_r + 1'b1;
      if (stk_rdata_r == idx_slot) begin
        found_nxt = 1'b1;
      end
    end

    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_cnt_r  <= '0;
      used_r      <= '0;
      scan_ptr_r  <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      free_cnt_r  <= free_cnt_nxt;
      used_r      <= used_nxt;
      scan_ptr_r  <= scan_ptr_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request, result and output payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r   <= ghal_pkg::mode_t'(in_tdata[ghal_pkg::MODE_W-1:0]);
      idx_r    <= in_tdata[ghal_pkg::MODE_W +: ghal_pkg::IDX_IN_W];
      gen_in_r <= in_tdata[ghal_pkg::MODE_W + ghal_pkg::IDX_IN_W +: ghal_pkg::GEN_IN_W];
    end
    if (cmd.slot_rd_pop) begin
      slot_r <= stk_rdata_r;
    end
    if (cmd.res_load) begin
      res_alive_r  <= cmd.res_alive;
      res_status_r <= cmd.res_status;
      case (cmd.res_kind)
        ghal_pkg::RES_FRESH: begin
          res_index_r <= ghal_pkg::IDX_IN_W'(used_r);
          res_gen_r   <= ghal_pkg::GEN_IN_W'(GEN_BITS'(1));
        end
        ghal_pkg::RES_POP: begin
          res_index_r <= ghal_pkg::IDX_IN_W'(slot_r);
          res_gen_r   <= ghal_pkg::GEN_IN_W'(gen_bumped);
        end
        ghal_pkg::RES_ECHO: begin
          res_index_r <= idx_r;
          res_gen_r   <= ghal_pkg::GEN_IN_W'(gen_req);
        end
        default: begin
          res_index_r <= '0;
          res_gen_r   <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_data_r <= {4'b0000, res_status_r, res_alive_r, res_gen_r, res_index_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The free stack never holds more entries than there are used slots.
  a_free_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    32'(free_cnt_r) <= 32'(used_r))
    else $error("free stack holds more entries than used slots");

  // The table never grows past its capacity.
  a_used_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) <= 32'(CAPACITY))
    else $error("used slot count beyond capacity");

  // A pop is issued only on a non-empty stack and shrinks it by one.
  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.stk_rd_top |-> !sts.free_empty ##1 (free_cnt_r == $past(free_cnt_r) - 1'b1))
    else $error("pop from free stack mis-counted");

  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result overwritten before being taken");

endmodule

`default_nettype wire

// File: rtl/generational_handle_allocator_unit.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit: generational handle allocator
// Hands out and checks handles made of a slot index and a generation.
//
// Usage:
//   Requests arrive on the in_ stream, one word each, with mode, slot index
//   and generation; each yields exactly one result word on the out_ stream.
//   Steps from one acceptance to the next while the receiver keeps up (the
//   result word is loaded into the output register in the result step):
//     allocate from the free stack: stack read, then table read-modify-write
//     fresh allocate, table full, out of range, release or query beyond the
//     used count: decode, then result; release and query: handle check;
//     allocate at an already active index: slot check
//     allocate at or above the used count: one grow step per skipped slot
//     allocate at a free index below it: a walk of the free stack, one entry
//     per read and write step, then the table write.
//   Reset clears the used count and the free stack count; the slot table and
//   stack are not cleared, since only entries below those counts are read.
//   While the receiver stalls, the result waits in the output register; one
//   more request is processed and then held until the register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module generational_handle_allocator_unit #(
  parameter int CAPACITY = 256,
  parameter int GEN_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  // [1:0] mode, [9:2] slot_index, [25:10] slot_gen, [31:26] zero
  input  wire logic [ghal_pkg::IN_TDATA_W-1:0]  in_tdata,
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  // [7:0] out_index, [23:8] out_gen, [24] is_alive, [27:25] status, [31:28] zero
  output      logic [ghal_pkg::OUT_TDATA_W-1:0] out_tdata
);

  ghal_pkg::cmd_t cmd;
  ghal_pkg::sts_t sts;

  // Sequencer.
  ghal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Tables, counters and result registers.
  ghal_dp #(
    .CAPACITY (CAPACITY),
    .GEN_BITS (GEN_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
